// ----- rtl/qcnt_pkg.sv -----
// Package for the quadrature counter with home preset.
// Holds widths, register addresses, reset values, scaling constants and stage types.
// No dependencies.
package qcnt_pkg;

    localparam int COUNT_W = 32;
    localparam int SCALE_W = 16;
    localparam int LEN_W   = 16;
    localparam int MAG_W   = 18;
    localparam int PROD_W  = 47;
    localparam int X_W     = 26;
    localparam int RECIP_W = 27;
    localparam int QP_W    = X_W + RECIP_W;
    localparam int RECIP_SHIFT = 36;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_PRESET = 1'b0;
    localparam logic REG_SCALE  = 1'b1;

    localparam logic signed [COUNT_W-1:0] PRESET_RESET = 32'sd100;
    localparam logic [SCALE_W-1:0]        SCALE_RESET  = 16'd100;

    localparam logic [33:0]       HOME_ERR_LIMIT = 34'd100000;
    // A product at or above 65536 * 10000 saturates the length.
    localparam logic [PROD_W-1:0] LEN_SAT_LIMIT  = 47'd655360000;
    // ceil(2^36 / 625); exact floor division by 625 for values below 2^26.
    localparam logic [RECIP_W-1:0] RECIP_625     = 27'd109951163;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic                      up;
        logic                      step_err;
        logic                      homed;
        logic [MAG_W-1:0]          mag;
    } t_s1;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic                      up;
        logic                      step_err;
        logic                      homed;
        logic                      home_err;
        logic [PROD_W-1:0]         prod;
    } t_s2;

endpackage

// ----- rtl/qcnt_core.sv -----
// Counter state and per-sample decode for the quadrature counter.
// Holds count, last pins, direction and primed flag; depends on qcnt_pkg.
module qcnt_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [2:0]                          i_sample,
    input  logic signed [qcnt_pkg::COUNT_W-1:0] i_preset,
    output qcnt_pkg::t_s1                       o_res
);
    import qcnt_pkg::*;

    logic signed [COUNT_W-1:0] r_count, n_count;
    logic [2:0]                r_last;
    logic                      r_dir, n_dir;
    logic                      r_primed;

    logic [2:0]                w_changed;
    logic                      w_differ;
    logic                      w_err;
    logic signed [COUNT_W-1:0] w_step;
    logic                      w_home;
    logic signed [COUNT_W:0]   w_dif;
    logic [COUNT_W:0]          w_abs;

    always_comb begin
        w_changed = i_sample ^ r_last;
        w_differ  = i_sample[0] ^ i_sample[1];
        w_step    = r_count;
        n_dir     = r_dir;
        w_err     = 1'b0;
        if (r_primed) begin
            case (w_changed[1:0])
                2'b01: begin
                    n_dir  = ~w_differ;
                    w_step = w_differ ? r_count - 32'sd1 : r_count + 32'sd1;
                end
                2'b10: begin
                    n_dir  = w_differ;
                    w_step = w_differ ? r_count + 32'sd1 : r_count - 32'sd1;
                end
                2'b11: begin
                    w_err = 1'b1;
                end
                default: begin
                end
            endcase
        end
        w_home  = r_primed && w_changed[2] && n_dir && !i_sample[2];
        // The deviation is taken in 33 bits so it cannot wrap.
        w_dif   = {i_preset[COUNT_W-1], i_preset} - {w_step[COUNT_W-1], w_step};
        w_abs   = w_dif[COUNT_W] ? (COUNT_W+1)'(0) - w_dif : w_dif;
        n_count = w_home ? i_preset : w_step;

        o_res.count    = n_count;
        o_res.up       = n_dir;
        o_res.step_err = w_err;
        o_res.homed    = w_home;
        // Anything at or above 2^17 already exceeds the limit for any nonzero scale.
        o_res.mag      = (|w_abs[COUNT_W:MAG_W-1]) ? {MAG_W{1'b1}} : w_abs[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_last   <= '0;
            r_dir    <= 1'b0;
            r_primed <= 1'b0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_last   <= i_sample;
            r_dir    <= n_dir;
            r_primed <= 1'b1;
        end
    end

endmodule

// ----- rtl/quadrature_counter_with_home_preset_unit.sv -----
// Quadrature counter with home preset: top level with APB registers and result pipeline.
// Uses qcnt_pkg and qcnt_core.
// A result passes through the registers r_s1, r_s2 and r_out on its way to the output.
// Throughput: one request per cycle unless the output stalls; the count state is updated
// in the accept cycle and the length scaling runs through two pipeline registers behind it.
// Reset (synchronous, active low) clears the count, direction, stored pins, pipeline valids
// and loads the register reset values.
module quadrature_counter_with_home_preset_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: pin_a, pin_b, pin_home, zero fill.
    input  logic [qcnt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: position[31:0], length[47:32], moving_up, step_error,
    // homed, home_error, zero fill.
    output logic [qcnt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qcnt_pkg::PADDR_W-1:0]         paddr,
    input  logic [qcnt_pkg::PDATA_W-1:0]         pwdata,
    output logic [qcnt_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import qcnt_pkg::*;

    logic signed [COUNT_W-1:0] r_preset;
    logic [SCALE_W-1:0]        r_scale;

    t_s1                       w_res, r_s1;
    t_s2                       r_s2;
    logic                      r_v1, r_v2, r_v3;
    logic [OUT_TDATA_W-1:0]    r_out;

    logic                      w_move1, w_move2, w_move3, w_accept, w_wr;
    logic [33:0]               w_dev;
    logic [COUNT_W-2:0]        w_pos;
    logic [PROD_W-1:0]         w_prod;
    logic                      w_sat;
    logic [QP_W-1:0]           w_qp;
    logic [LEN_W-1:0]          w_len;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SCALE) ? {{(PDATA_W-SCALE_W){1'b0}}, r_scale}
                                            : r_preset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= PRESET_RESET;
            r_scale  <= SCALE_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_PRESET: r_preset <= pwdata;
                REG_SCALE:  r_scale  <= pwdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_move3       = !r_v3 || m_axis_tready;
    assign w_move2       = !r_v2 || w_move3;
    assign w_move1       = !r_v1 || w_move2;
    assign s_axis_tready = w_move1;
    assign w_accept      = s_axis_tvalid && w_move1;

    qcnt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sample (s_axis_tdata[2:0]),
        .i_preset (r_preset),
        .o_res    (w_res)
    );

    // Second stage: home deviation check and the raw length product.
    assign w_dev  = r_s1.mag * r_scale;
    assign w_pos  = r_s1.count[COUNT_W-1] ? '0 : r_s1.count[COUNT_W-2:0];
    assign w_prod = w_pos * r_scale;

    // Third stage: divide by 10000 as a shift by 4 and a reciprocal multiply by 1/625.
    assign w_sat  = r_s2.prod >= LEN_SAT_LIMIT;
    assign w_qp   = r_s2.prod[X_W+3:4] * RECIP_625;
    assign w_len  = w_sat ? {LEN_W{1'b1}} : w_qp[RECIP_SHIFT+LEN_W-1:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_move1) r_v1 <= s_axis_tvalid;
            if (w_move2) r_v2 <= r_v1;
            if (w_move3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_res;
        end
        if (w_move2 && r_v1) begin
            r_s2.count    <= r_s1.count;
            r_s2.up       <= r_s1.up;
            r_s2.step_err <= r_s1.step_err;
            r_s2.homed    <= r_s1.homed;
            r_s2.home_err <= r_s1.homed && (w_dev > HOME_ERR_LIMIT);
            r_s2.prod     <= w_prod;
        end
        if (w_move3 && r_v2) begin
            r_out <= {4'b0000, r_s2.home_err, r_s2.homed, r_s2.step_err, r_s2.up,
                      w_len, r_s2.count};
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out;

endmodule

// ----- rtl/qcnt_checker.sv -----
// Port-level checker for the quadrature counter with home preset, with its bind.
// Depends on qcnt_pkg and the top-level port list.
module qcnt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [qcnt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import qcnt_pkg::*;

    // The result pipeline is empty right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A home error is only reported together with a preset.
    a_err_homed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[51] |-> m_axis_tdata[50])
        else $error("home error without preset");

    // Presetting happens only while the last step was upward.
    a_homed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[48])
        else $error("preset while moving down");

    // A negative position always scales to zero length.
    a_neg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[47:32] == '0)
        else $error("nonzero length for negative position");

endmodule

bind quadrature_counter_with_home_preset_unit qcnt_checker u_qcnt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
